@@ rtl/core/double_ended_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue
// Both macros sample on i_clk and are switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define DEQ_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared widths, operation and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KIND_W        = 3;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_READ_ALL   = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_ROTATE
    } t_cell_op;

    // Broadcast to every cell of the chain in each cycle.
    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] push_value;
        logic signed [DATA_W-1:0] head_value;
    } t_cell_ctrl;

endpackage

@@ rtl/core/deq_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Carries one operation request per beat into the queue.
// ----------------------------------------------------------------------------
interface deq_cmd_if
    import deq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

@@ rtl/core/deq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel
// Carries one result per beat out of the queue.
// ----------------------------------------------------------------------------
interface deq_rsp_if
    import deq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] entry_value;
    logic [STATUS_W-1:0]      status;
    logic                     final_result;

    modport source (output valid, output entry_value, output status,
                    output final_result, input ready);
    modport sink (input valid, input entry_value, input status,
                  input final_result, output ready);
endinterface

@@ rtl/core/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// A bounded deque of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// The front entry always sits in cell 0 and the entries follow in order along
// the row. A push or pop at either end gives one result beat. A read-out of
// a queue holding N entries first takes the command and then gives one beat
// per entry, because the occupied cells turn by one place past cell 0 with
// each beat, leaving the order as it was. A read-out of an empty queue gives
// one beat. While a read-out is running no command is taken. A result waits
// in an output register, and a new command is taken whenever that register
// is empty or is being emptied in the same cycle. No clearing pass is needed
// after reset.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    deq_cmd_if.sink   i_cmd,
    deq_rsp_if.source o_rsp
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] C_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] C_ONE  = CW'(1);

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CW-1:0]            r_left;
    logic [CW-1:0]            n_left;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic [STATUS_W-1:0]      r_out_status;
    logic                     r_out_final;

    logic                     w_slot_free;
    logic                     w_fire;
    logic                     w_emit;
    logic signed [DATA_W-1:0] w_emit_value;
    t_status                  w_emit_status;
    logic                     w_emit_final;
    logic [CW-1:0]            w_tail;
    logic signed [DATA_W-1:0] w_tail_value;
    t_cell_ctrl               w_ctrl;
    logic                     w_readout;
    logic                     w_readout_step;
    logic                     w_push_full;

    logic signed [DATA_W-1:0] w_data      [DEPTH];
    logic signed [DATA_W-1:0] w_tail_term [DEPTH];

    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && w_slot_free;
    assign w_fire      = i_cmd.valid && i_cmd.ready;
    assign w_tail      = r_count - C_ONE;

    assign w_readout      = (r_state == ST_READOUT);
    assign w_readout_step = w_readout && w_slot_free;
    assign w_push_full    = w_fire && (r_count == C_FULL) &&
                            (i_cmd.kind == KIND_PUSH_FRONT || i_cmd.kind == KIND_PUSH_BACK);

    always_comb begin
        w_tail_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tail_value = w_tail_value | w_tail_term[k];
        end
    end

    always_comb begin
        w_ctrl.op         = CELL_HOLD;
        w_ctrl.push_value = i_cmd.value;
        w_ctrl.head_value = w_data[0];
        n_state           = r_state;
        n_count           = r_count;
        n_left            = r_left;
        w_emit            = 1'b0;
        w_emit_value      = '0;
        w_emit_status     = STATUS_OK;
        w_emit_final      = 1'b1;
        if (w_fire) begin
            case (i_cmd.kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                    w_emit = 1'b1;
                    if (r_count == C_FULL) begin
                        w_emit_status = STATUS_FULL;
                    end else begin
                        w_ctrl.op = (i_cmd.kind == KIND_PUSH_FRONT) ?
                                    CELL_PUSH_FRONT : CELL_PUSH_BACK;
                        n_count   = r_count + C_ONE;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK: begin
                    w_emit = 1'b1;
                    if (r_count == '0) begin
                        w_emit_status = STATUS_EMPTY;
                    end else begin
                        n_count = r_count - C_ONE;
                        if (i_cmd.kind == KIND_POP_FRONT) begin
                            w_ctrl.op    = CELL_POP_FRONT;
                            w_emit_value = w_data[0];
                        end else begin
                            w_emit_value = w_tail_value;
                        end
                    end
                end
                KIND_READ_ALL: begin
                    if (r_count == '0) begin
                        w_emit        = 1'b1;
                        w_emit_status = STATUS_EMPTY;
                    end else begin
                        n_state = ST_READOUT;
                        n_left  = r_count;
                    end
                end
                default: w_emit = 1'b0;
            endcase
        end else if (r_state == ST_READOUT && w_slot_free) begin
            w_ctrl.op    = CELL_ROTATE;
            w_emit       = 1'b1;
            w_emit_value = w_data[0];
            w_emit_final = (r_left == C_ONE);
            n_left       = r_left - C_ONE;
            if (r_left == C_ONE) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_emit) begin
            r_out_value  <= w_emit_value;
            r_out_status <= w_emit_status;
            r_out_final  <= w_emit_final;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.entry_value  = r_out_value;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.final_result = r_out_final;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_cmd.value;
        end else begin : g_inner_left
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_right
            assign w_right = w_data[g+1];
        end

        deq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_count     (r_count),
            .i_tail      (w_tail),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_data      (w_data[g]),
            .o_tail_term (w_tail_term[g])
        );
    end

`include "double_ended_queue_assert.svh"

    `DEQ_ASSERT_ALWAYS(a_count_bound, r_count <= C_FULL, "entry count beyond depth")
    `DEQ_ASSERT_ALWAYS(a_readout_nonempty, !w_readout || r_count != '0, "read-out of empty queue")
    `DEQ_ASSERT_NEXT(a_full_push_drops, w_push_full, $stable(r_count), "full push changed count")
    `DEQ_ASSERT_NEXT(a_readout_beat, w_readout_step, r_out_valid && r_out_status == STATUS_OK, "no beat")

endmodule

@@ rtl/core/deq_cell.sv @@
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry and takes a neighbour's entry, the pushed or the head value.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                             i_clk,
    input  t_cell_ctrl                       i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]       i_count,
    input  logic [$clog2(DEPTH+1)-1:0]       i_tail,
    input  logic signed [DATA_W-1:0]         i_left,
    input  logic signed [DATA_W-1:0]         i_right,
    output logic signed [DATA_W-1:0]         o_data,
    output logic signed [DATA_W-1:0]         o_tail_term
);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] C_IDX = CW'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_is_tail;

    assign w_is_tail = (C_IDX == i_tail);

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_PUSH_FRONT: n_data = i_left;
            CELL_PUSH_BACK: begin
                if (C_IDX == i_count) begin
                    n_data = i_ctrl.push_value;
                end
            end
            CELL_POP_FRONT: n_data = i_right;
            // The tail cell closes the ring so the occupied part turns by one.
            CELL_ROTATE: n_data = w_is_tail ? i_ctrl.head_value : i_right;
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_tail_term = w_is_tail ? r_data : '0;
endmodule
